// File: rtl/jmcm_pkg.sv
// Shared types, codes and constants for the joystick motion command mapper.
`timescale 1ns / 1ps

package jmcm_pkg;

    localparam int NUM_AXES_DEF    = 8;
    localparam int NUM_BUTTONS_DEF = 16;

    localparam int AXIS_W = 16;
    localparam int BTN_W  = 16;
    localparam int VAL_W  = 24;
    localparam int MAP_W  = 36;
    localparam int APB_AW = 6;
    localparam int APB_DW = 64;
    localparam int SLOT_W = 3;

    // result kinds
    localparam logic [1:0] KIND_GESTURE = 2'd0;
    localparam logic [1:0] KIND_VEL     = 2'd1;
    localparam logic [1:0] KIND_POSE    = 2'd2;
    localparam logic [1:0] KIND_STOP    = 2'd3;

    // register indexes
    localparam logic [2:0] REG_DEADZONE = 3'd0;
    localparam logic [2:0] REG_GAIN_FWD = 3'd1;
    localparam logic [2:0] REG_GAIN_SID = 3'd2;
    localparam logic [2:0] REG_GAIN_TRN = 3'd3;
    localparam logic [2:0] REG_GAIN_PIT = 3'd4;
    localparam logic [2:0] REG_BASE_HT  = 3'd5;
    localparam logic [2:0] REG_TIMEOUT  = 3'd6;
    localparam logic [2:0] REG_CTRL_MAP = 3'd7;

    // reset values
    localparam logic [14:0]       RST_DEADZONE = 15'd3277;
    localparam logic signed [15:0] RST_GAIN    = 16'sd256;
    localparam logic signed [15:0] RST_BASE    = 16'sd0;
    localparam logic [15:0]       RST_TIMEOUT  = 16'd5;
    localparam logic [MAP_W-1:0]  RST_MAP      = 36'd16017601;

    // fixed pose scales, Q8.8
    localparam logic signed [15:0] SCALE_HEIGHT = 16'sd3840;
    localparam logic signed [15:0] SCALE_SHIFT  = 16'sd3072;
    localparam logic signed [15:0] SCALE_YAW    = 16'sd77;

    // axis computation slots
    localparam logic [SLOT_W-1:0] SLOT_A = 3'd0;
    localparam logic [SLOT_W-1:0] SLOT_B = 3'd1;
    localparam logic [SLOT_W-1:0] SLOT_C = 3'd2;
    localparam logic [SLOT_W-1:0] SLOT_D = 3'd3;
    localparam logic [SLOT_W-1:0] SLOT_E = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_AXIS,
        S_AXWAIT,
        S_RESULT,
        S_STOP
    } t_state;

    typedef enum logic [1:0] {
        P_IDLE,
        P_DIV,
        P_MUL,
        P_FIN
    } t_phase;

    typedef struct packed {
        logic              capture;
        logic              ax_start;
        logic [SLOT_W-1:0] slot;
        logic              pose;
        logic              out_load;
        logic [1:0]        out_kind;
        logic [3:0]        out_button;
        logic              out_last;
    } t_cmd;

    typedef struct packed {
        logic axis_done;
        logic busy;
    } t_sts;

endpackage

// File: rtl/joystick_motion_command_mapper_top.sv
// Top level: configuration registers, controller and datapath.
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// request   in         i_valid / o_ready  i_req_type, i_axis_0..7, i_button_bits
// result    out        o_valid / i_ready  o_kind, o_gesture_button, o_value_a..e, o_last
// config    in         APB psel/penable   paddr (8-byte stride), pwdata, prdata
//
// A frame is accepted and its buttons are scanned for gestures, then each axis goes
// through the shared divider and multiplier (an axis in the deadzone, unmapped or at
// full scale skips the divide), then the result is loaded: a velocity command, or a
// pose followed by its trailing stop when one is still due.
// One transaction is worked at a time; a result register holds while the consumer
// stalls, and the gesture scan and result and stop loads wait, but axis steps run on.
// Synchronous active-low reset restores register defaults and the control state.

module joystick_motion_command_mapper_top #(
    parameter int NUM_AXES    = jmcm_pkg::NUM_AXES_DEF,
    parameter int NUM_BUTTONS = jmcm_pkg::NUM_BUTTONS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_req_type,
    input  logic signed [15:0]                i_axis_0,
    input  logic signed [15:0]                i_axis_1,
    input  logic signed [15:0]                i_axis_2,
    input  logic signed [15:0]                i_axis_3,
    input  logic signed [15:0]                i_axis_4,
    input  logic signed [15:0]                i_axis_5,
    input  logic signed [15:0]                i_axis_6,
    input  logic signed [15:0]                i_axis_7,
    input  logic [15:0]                       i_button_bits,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [1:0]                        o_kind,
    output logic [3:0]                        o_gesture_button,
    output logic signed [23:0]                o_value_a,
    output logic signed [23:0]                o_value_b,
    output logic signed [23:0]                o_value_c,
    output logic signed [23:0]                o_value_d,
    output logic signed [23:0]                o_value_e,
    output logic                              o_last,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [jmcm_pkg::APB_AW-1:0]       paddr,
    input  logic [jmcm_pkg::APB_DW-1:0]       pwdata,
    output logic [jmcm_pkg::APB_DW-1:0]       prdata,
    output logic                              pready
);

    logic [14:0]        r_deadzone;
    logic signed [15:0] r_gain_fwd, r_gain_sid, r_gain_trn, r_gain_pit, r_base_ht;
    logic [15:0]        r_timeout;
    logic [jmcm_pkg::MAP_W-1:0] r_ctrl_map;

    logic [2:0] w_reg;
    logic       w_wr;
    logic [15:0] w_all [8];
    logic [NUM_AXES-1:0][15:0] w_axes;
    jmcm_pkg::t_cmd w_cmd;
    jmcm_pkg::t_sts w_sts;

    assign pready = 1'b1;
    assign w_reg  = paddr[5:3];
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadzone <= jmcm_pkg::RST_DEADZONE;
            r_gain_fwd <= jmcm_pkg::RST_GAIN;
            r_gain_sid <= jmcm_pkg::RST_GAIN;
            r_gain_trn <= jmcm_pkg::RST_GAIN;
            r_gain_pit <= jmcm_pkg::RST_GAIN;
            r_base_ht  <= jmcm_pkg::RST_BASE;
            r_timeout  <= jmcm_pkg::RST_TIMEOUT;
            r_ctrl_map <= jmcm_pkg::RST_MAP;
        end else if (w_wr) begin
            unique case (w_reg)
                jmcm_pkg::REG_DEADZONE: r_deadzone <= pwdata[14:0];
                jmcm_pkg::REG_GAIN_FWD: r_gain_fwd <= pwdata[15:0];
                jmcm_pkg::REG_GAIN_SID: r_gain_sid <= pwdata[15:0];
                jmcm_pkg::REG_GAIN_TRN: r_gain_trn <= pwdata[15:0];
                jmcm_pkg::REG_GAIN_PIT: r_gain_pit <= pwdata[15:0];
                jmcm_pkg::REG_BASE_HT:  r_base_ht  <= pwdata[15:0];
                jmcm_pkg::REG_TIMEOUT:  r_timeout  <= pwdata[15:0];
                jmcm_pkg::REG_CTRL_MAP: r_ctrl_map <= pwdata[jmcm_pkg::MAP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            jmcm_pkg::REG_DEADZONE: prdata = 64'(r_deadzone);
            jmcm_pkg::REG_GAIN_FWD: prdata = 64'($unsigned(r_gain_fwd));
            jmcm_pkg::REG_GAIN_SID: prdata = 64'($unsigned(r_gain_sid));
            jmcm_pkg::REG_GAIN_TRN: prdata = 64'($unsigned(r_gain_trn));
            jmcm_pkg::REG_GAIN_PIT: prdata = 64'($unsigned(r_gain_pit));
            jmcm_pkg::REG_BASE_HT:  prdata = 64'($unsigned(r_base_ht));
            jmcm_pkg::REG_TIMEOUT:  prdata = 64'(r_timeout);
            default:                prdata = 64'(r_ctrl_map);
        endcase
    end

    assign w_all[0] = i_axis_0;
    assign w_all[1] = i_axis_1;
    assign w_all[2] = i_axis_2;
    assign w_all[3] = i_axis_3;
    assign w_all[4] = i_axis_4;
    assign w_all[5] = i_axis_5;
    assign w_all[6] = i_axis_6;
    assign w_all[7] = i_axis_7;

    always_comb begin
        for (int k = 0; k < NUM_AXES; k++) w_axes[k] = w_all[k];
    end

    jmcm_ctrl #(.NUM_BUTTONS(NUM_BUTTONS)) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_req_type    (i_req_type),
        .i_button_bits (i_button_bits),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .i_control_map (r_ctrl_map),
        .i_timeout     (r_timeout),
        .i_sts         (w_sts),
        .o_cmd         (w_cmd)
    );

    jmcm_dp #(.NUM_AXES(NUM_AXES)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_axes           (w_axes),
        .i_deadzone       (r_deadzone),
        .i_gain_forward   (r_gain_fwd),
        .i_gain_sideways  (r_gain_sid),
        .i_gain_turn      (r_gain_trn),
        .i_gain_pitch     (r_gain_pit),
        .i_base_height    (r_base_ht),
        .i_control_map    (r_ctrl_map),
        .o_kind           (o_kind),
        .o_gesture_button (o_gesture_button),
        .o_value_a        (o_value_a),
        .o_value_b        (o_value_b),
        .o_value_c        (o_value_c),
        .o_value_d        (o_value_d),
        .o_value_e        (o_value_e),
        .o_last           (o_last)
    );

`ifndef SYNTHESIS
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!o_valid || i_ready))
        else $error("result loaded over a pending transaction");
    a_idle_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !w_sts.busy)
        else $error("input ready while axis unit busy");
    a_capture_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.capture |-> (i_valid && o_ready && !i_req_type))
        else $error("axis capture without frame transaction");
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.axis_done |-> !o_ready)
        else $error("axis result while controller idle");
`endif

endmodule

// File: rtl/jmcm_ctrl.sv
// Controller: frame and tick sequencing, gesture scan, stop and watchdog state.
`timescale 1ns / 1ps

module jmcm_ctrl #(
    parameter int NUM_BUTTONS = jmcm_pkg::NUM_BUTTONS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_req_type,
    input  logic [jmcm_pkg::BTN_W-1:0]  i_button_bits,
    output logic                        o_valid,
    input  logic                        i_ready,
    input  logic [jmcm_pkg::MAP_W-1:0]  i_control_map,
    input  logic [15:0]                 i_timeout,
    input  jmcm_pkg::t_sts              i_sts,
    output jmcm_pkg::t_cmd              o_cmd
);

    localparam int BW = (NUM_BUTTONS > 8) ? 4 : 3;
    localparam logic [BW-1:0] LAST_IDX = BW'(NUM_BUTTONS - 1);
    localparam logic [15:0] BTN_MASK = 16'((32'd1 << NUM_BUTTONS) - 32'd1);

    jmcm_pkg::t_state r_state, n_state;

    logic [15:0]   r_prior, n_prior;
    logic [15:0]   r_pend, n_pend;
    logic [15:0]   r_quiet, n_quiet;
    logic [BW-1:0] r_idx, n_idx;
    logic [jmcm_pkg::SLOT_W-1:0] r_slot, n_slot;
    logic r_stop_sent, n_stop_sent;
    logic r_frame_seen, n_frame_seen;
    logic r_posture, n_posture;
    logic r_deadman, n_deadman;
    logic r_out_valid, n_out_valid;

    logic [3:0]  w_deadman_idx, w_posture_idx;
    logic [15:0] w_gmask, w_btn, w_rise, w_quiet_inc;
    logic        w_free, w_acc, w_fire, w_bit, w_step, w_end, w_trail;
    logic        w_post_held, w_dead_held, w_last_slot;

    assign w_deadman_idx = i_control_map[15:12];
    assign w_posture_idx = i_control_map[19:16];
    assign w_gmask       = i_control_map[35:20];
    assign w_btn         = i_button_bits & BTN_MASK;
    assign w_rise        = w_gmask & w_btn & ~r_prior;
    assign w_post_held   = ({1'b0, w_posture_idx} < 5'(NUM_BUTTONS)) && w_btn[w_posture_idx];
    assign w_dead_held   = ({1'b0, w_deadman_idx} < 5'(NUM_BUTTONS)) && w_btn[w_deadman_idx];

    assign w_free  = !r_out_valid || i_ready;
    assign o_ready = (r_state == jmcm_pkg::S_IDLE) && w_free;
    assign o_valid = r_out_valid;
    assign w_acc   = i_valid && o_ready;

    assign w_quiet_inc = (r_quiet == 16'hFFFF) ? r_quiet : r_quiet + 16'd1;
    assign w_fire      = r_frame_seen && !r_stop_sent && (w_quiet_inc > i_timeout);

    assign w_bit   = r_pend[r_idx];
    assign w_step  = !w_bit || w_free;
    assign w_end   = (r_idx == LAST_IDX) && w_step;
    assign w_trail = r_posture || r_deadman || !r_stop_sent;
    assign w_last_slot = r_posture ? (r_slot == jmcm_pkg::SLOT_E)
                                   : (r_slot == jmcm_pkg::SLOT_C);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            jmcm_pkg::S_IDLE: begin
                if (w_acc && !i_req_type) n_state = jmcm_pkg::S_SCAN;
            end
            jmcm_pkg::S_SCAN: begin
                if (w_end) begin
                    if (r_posture || r_deadman) n_state = jmcm_pkg::S_AXIS;
                    else if (!r_stop_sent)      n_state = jmcm_pkg::S_STOP;
                    else                        n_state = jmcm_pkg::S_IDLE;
                end
            end
            jmcm_pkg::S_AXIS: n_state = jmcm_pkg::S_AXWAIT;
            jmcm_pkg::S_AXWAIT: begin
                if (i_sts.axis_done)
                    n_state = w_last_slot ? jmcm_pkg::S_RESULT : jmcm_pkg::S_AXIS;
            end
            jmcm_pkg::S_RESULT: begin
                if (w_free)
                    n_state = (r_posture && !r_stop_sent) ? jmcm_pkg::S_STOP
                                                          : jmcm_pkg::S_IDLE;
            end
            jmcm_pkg::S_STOP: begin
                if (w_free) n_state = jmcm_pkg::S_IDLE;
            end
            default: n_state = jmcm_pkg::S_IDLE;
        endcase
    end

    // outputs and state updates
    always_comb begin
        o_cmd        = '0;
        o_cmd.slot   = r_slot;
        o_cmd.pose   = r_posture;
        n_prior      = r_prior;
        n_pend       = r_pend;
        n_quiet      = r_quiet;
        n_idx        = r_idx;
        n_slot       = r_slot;
        n_stop_sent  = r_stop_sent;
        n_frame_seen = r_frame_seen;
        n_posture    = r_posture;
        n_deadman    = r_deadman;
        n_out_valid  = r_out_valid && !i_ready;
        unique case (r_state)
            jmcm_pkg::S_IDLE: begin
                if (w_acc && i_req_type) begin
                    if (r_frame_seen) n_quiet = w_quiet_inc;
                    if (w_fire) begin
                        o_cmd.out_load     = 1'b1;
                        o_cmd.out_kind     = jmcm_pkg::KIND_STOP;
                        o_cmd.out_last     = 1'b1;
                        n_out_valid        = 1'b1;
                        n_stop_sent        = 1'b1;
                    end
                end else if (w_acc) begin
                    o_cmd.capture = 1'b1;
                    n_frame_seen  = 1'b1;
                    n_quiet       = '0;
                    n_pend        = w_rise;
                    n_prior       = w_btn;
                    n_idx         = '0;
                    n_slot        = jmcm_pkg::SLOT_A;
                    n_posture     = w_post_held;
                    n_deadman     = w_dead_held;
                end
            end
            jmcm_pkg::S_SCAN: begin
                if (w_bit && w_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_kind   = jmcm_pkg::KIND_GESTURE;
                    o_cmd.out_button = 4'(r_idx);
                    o_cmd.out_last   = ((r_pend & ~(16'd1 << r_idx)) == '0) && !w_trail;
                    n_out_valid      = 1'b1;
                    n_pend           = r_pend & ~(16'd1 << r_idx);
                end
                if (w_step && !w_end) n_idx = r_idx + BW'(1);
            end
            jmcm_pkg::S_AXIS: begin
                o_cmd.ax_start = 1'b1;
            end
            jmcm_pkg::S_AXWAIT: begin
                if (i_sts.axis_done && !w_last_slot) n_slot = r_slot + jmcm_pkg::SLOT_W'(1);
            end
            jmcm_pkg::S_RESULT: begin
                if (w_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_kind = r_posture ? jmcm_pkg::KIND_POSE : jmcm_pkg::KIND_VEL;
                    o_cmd.out_last = r_posture ? r_stop_sent : 1'b1;
                    n_out_valid    = 1'b1;
                    if (!r_posture) n_stop_sent = 1'b0;
                end
            end
            jmcm_pkg::S_STOP: begin
                if (w_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_kind = jmcm_pkg::KIND_STOP;
                    o_cmd.out_last = 1'b1;
                    n_out_valid    = 1'b1;
                    n_stop_sent    = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= jmcm_pkg::S_IDLE;
            r_prior      <= '0;
            r_pend       <= '0;
            r_quiet      <= '0;
            r_idx        <= '0;
            r_slot       <= jmcm_pkg::SLOT_A;
            r_stop_sent  <= 1'b0;
            r_frame_seen <= 1'b0;
            r_posture    <= 1'b0;
            r_deadman    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_prior      <= n_prior;
            r_pend       <= n_pend;
            r_quiet      <= n_quiet;
            r_idx        <= n_idx;
            r_slot       <= n_slot;
            r_stop_sent  <= n_stop_sent;
            r_frame_seen <= n_frame_seen;
            r_posture    <= n_posture;
            r_deadman    <= n_deadman;
            r_out_valid  <= n_out_valid;
        end
    end

endmodule

// File: rtl/jmcm_dp.sv
// Datapath: axis capture, deadzone rescale divider, gain multiply, output register.
`timescale 1ns / 1ps

module jmcm_dp #(
    parameter int NUM_AXES = jmcm_pkg::NUM_AXES_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  jmcm_pkg::t_cmd                        i_cmd,
    output jmcm_pkg::t_sts                        o_sts,
    input  logic [NUM_AXES-1:0][jmcm_pkg::AXIS_W-1:0] i_axes,
    input  logic [14:0]                           i_deadzone,
    input  logic signed [15:0]                    i_gain_forward,
    input  logic signed [15:0]                    i_gain_sideways,
    input  logic signed [15:0]                    i_gain_turn,
    input  logic signed [15:0]                    i_gain_pitch,
    input  logic signed [15:0]                    i_base_height,
    input  logic [jmcm_pkg::MAP_W-1:0]            i_control_map,
    output logic [1:0]                            o_kind,
    output logic [3:0]                            o_gesture_button,
    output logic signed [jmcm_pkg::VAL_W-1:0]     o_value_a,
    output logic signed [jmcm_pkg::VAL_W-1:0]     o_value_b,
    output logic signed [jmcm_pkg::VAL_W-1:0]     o_value_c,
    output logic signed [jmcm_pkg::VAL_W-1:0]     o_value_d,
    output logic signed [jmcm_pkg::VAL_W-1:0]     o_value_e,
    output logic                                  o_last
);

    localparam int AXW = $clog2(NUM_AXES);
    localparam logic signed [24:0] SAT_MAX = 25'sd8388607;
    localparam logic signed [24:0] SAT_MIN = -25'sd8388608;

    logic [jmcm_pkg::AXIS_W-1:0] r_axis [NUM_AXES];
    logic signed [jmcm_pkg::VAL_W-1:0] r_val [5];

    jmcm_pkg::t_phase r_phase;
    logic [15:0] r_rem, r_den, r_q, r_g;
    logic [3:0]  r_cnt;
    logic [31:0] r_prod;
    logic        r_neg, r_done;
    logic [jmcm_pkg::SLOT_W-1:0] r_slot;
    logic        r_pose;

    logic [2:0]         w_idx;
    logic signed [15:0] w_gain;
    logic [15:0]        w_a, w_n, w_d;
    logic [16:0]        w_m, w_rem2;
    logic               w_zero, w_ge;
    logic [16:0]        w_rq;
    logic signed [24:0] w_s, w_sum;
    logic signed [jmcm_pkg::VAL_W-1:0] w_sat;

    // pick axis and gain for the requested slot
    always_comb begin
        w_idx  = i_control_map[2:0];
        w_gain = i_gain_forward;
        if (i_cmd.pose) begin
            unique case (i_cmd.slot)
                jmcm_pkg::SLOT_A: begin w_idx = i_control_map[2:0];  w_gain = jmcm_pkg::SCALE_HEIGHT; end
                jmcm_pkg::SLOT_B: begin w_idx = i_control_map[11:9]; w_gain = jmcm_pkg::SCALE_SHIFT; end
                jmcm_pkg::SLOT_C: begin w_idx = i_control_map[5:3];  w_gain = jmcm_pkg::SCALE_SHIFT; end
                jmcm_pkg::SLOT_D: begin w_idx = i_control_map[11:9]; w_gain = i_gain_pitch; end
                default:          begin w_idx = i_control_map[8:6];  w_gain = jmcm_pkg::SCALE_YAW; end
            endcase
        end else begin
            unique case (i_cmd.slot)
                jmcm_pkg::SLOT_A: begin w_idx = i_control_map[2:0]; w_gain = i_gain_forward; end
                jmcm_pkg::SLOT_B: begin w_idx = i_control_map[5:3]; w_gain = i_gain_sideways; end
                default:          begin w_idx = i_control_map[8:6]; w_gain = i_gain_turn; end
            endcase
        end
    end

    assign w_a    = r_axis[w_idx[AXW-1:0]];
    assign w_m    = w_a[15] ? (17'd0 - {w_a[15], w_a}) : {1'b0, w_a};
    assign w_zero = ({1'b0, w_idx} >= 4'(NUM_AXES)) || (w_m < {2'b00, i_deadzone});
    assign w_n    = 16'(w_m - {2'b00, i_deadzone});
    assign w_d    = 16'(17'd32768 - {2'b00, i_deadzone});

    assign w_rem2 = {r_rem, 1'b0};
    assign w_ge   = w_rem2 >= {1'b0, r_den};

    // round Q.23 product to Q.8, then sign and optional height offset
    assign w_rq  = 17'((33'(r_prod) + 33'd16384) >> 15);
    assign w_s   = r_neg ? -$signed({8'd0, w_rq}) : $signed({8'd0, w_rq});
    assign w_sum = (r_pose && (r_slot == jmcm_pkg::SLOT_A))
                 ? w_s + 25'(i_base_height) : w_s;
    assign w_sat = (w_sum > SAT_MAX) ? SAT_MAX[23:0]
                 : (w_sum < SAT_MIN) ? SAT_MIN[23:0] : w_sum[23:0];

    assign o_sts.axis_done = r_done;
    assign o_sts.busy      = (r_phase != jmcm_pkg::P_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= jmcm_pkg::P_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_phase)
                jmcm_pkg::P_IDLE: begin
                    if (i_cmd.ax_start) begin
                        if (w_zero || (w_n == w_d)) r_phase <= jmcm_pkg::P_MUL;
                        else                        r_phase <= jmcm_pkg::P_DIV;
                    end
                end
                jmcm_pkg::P_DIV: begin
                    if (r_cnt == 4'd14) r_phase <= jmcm_pkg::P_MUL;
                end
                jmcm_pkg::P_MUL: r_phase <= jmcm_pkg::P_FIN;
                jmcm_pkg::P_FIN: begin
                    r_phase <= jmcm_pkg::P_IDLE;
                    r_done  <= 1'b1;
                end
                default: r_phase <= jmcm_pkg::P_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            for (int k = 0; k < NUM_AXES; k++) r_axis[k] <= i_axes[k];
        end
        if (i_cmd.ax_start) begin
            r_slot <= i_cmd.slot;
            r_pose <= i_cmd.pose;
            r_neg  <= w_a[15] ^ w_gain[15];
            r_g    <= w_gain[15] ? 16'(17'd0 - 17'(w_gain)) : w_gain;
            r_den  <= w_d;
            r_rem  <= w_n;
            r_cnt  <= '0;
            if (w_zero)             r_q <= '0;
            else if (w_n == w_d)    r_q <= 16'h8000;
            else                    r_q <= '0;
        end
        if (r_phase == jmcm_pkg::P_DIV) begin
            r_rem <= w_ge ? 16'(w_rem2 - {1'b0, r_den}) : w_rem2[15:0];
            r_q   <= {r_q[14:0], w_ge};
            r_cnt <= r_cnt + 4'd1;
        end
        if (r_phase == jmcm_pkg::P_MUL) r_prod <= r_q * r_g;
        if (r_phase == jmcm_pkg::P_FIN) r_val[r_slot] <= w_sat;
        if (i_cmd.out_load) begin
            o_kind           <= i_cmd.out_kind;
            o_gesture_button <= i_cmd.out_button;
            o_last           <= i_cmd.out_last;
            o_value_a <= '0;
            o_value_b <= '0;
            o_value_c <= '0;
            o_value_d <= '0;
            o_value_e <= '0;
            if (i_cmd.out_kind == jmcm_pkg::KIND_VEL || i_cmd.out_kind == jmcm_pkg::KIND_POSE) begin
                o_value_a <= r_val[0];
                o_value_b <= r_val[1];
                o_value_c <= r_val[2];
            end
            if (i_cmd.out_kind == jmcm_pkg::KIND_POSE) begin
                o_value_d <= r_val[3];
                o_value_e <= r_val[4];
            end
        end
    end

endmodule

// File: bench/tb_joystick_motion_command_mapper_top.sv
// Self-checking bench for the joystick motion command mapper top level.
`timescale 1ns / 1ps

module tb_joystick_motion_command_mapper_top;

    typedef struct {
        logic        req_type;
        logic [15:0] axis [8];
        logic [15:0] buttons;
    } t_frame;

    typedef struct {
        logic [1:0]  kind;
        logic [3:0]  button;
        logic [23:0] val [5];
        logic        last;
    } t_motion;

    // directed rows: stimulus plus an optional typed-in expectation
    typedef struct {
        logic        req_type;
        logic [15:0] ax0;
        logic [15:0] ax1;
        logic [15:0] buttons;
        logic        typed;
        logic [1:0]  kind;
        logic [3:0]  button;
        logic [23:0] va;
    } t_row;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        req_type;
    logic signed [15:0] ax [8];
    logic [15:0] button_bits;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  kind;
    logic [3:0]  gesture_button;
    logic signed [23:0] va, vb, vc, vd, ve;
    logic        last;
    logic        psel, penable, pwrite;
    logic [jmcm_pkg::APB_AW-1:0] paddr;
    logic [jmcm_pkg::APB_DW-1:0] pwdata;
    logic [jmcm_pkg::APB_DW-1:0] prdata;
    logic        pready;

    // predictor state and shadow registers
    logic [14:0]        dz;
    logic signed [15:0] g_fwd, g_side, g_turn, g_pitch, base_ht;
    logic [15:0]        timeout;
    logic [35:0]        cmap;
    logic [15:0]        prev_buttons;
    logic               stopped;
    logic               seen_frame;
    logic [15:0]        quiet;

    t_motion expected_motion [$];
    int      fail_count;
    int      result_count;
    int      idle_cycles;
    int      send_idle_pct;
    int      recv_idle_pct;

    joystick_motion_command_mapper_top i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_ready(in_ready), .i_req_type(req_type),
        .i_axis_0(ax[0]), .i_axis_1(ax[1]), .i_axis_2(ax[2]), .i_axis_3(ax[3]),
        .i_axis_4(ax[4]), .i_axis_5(ax[5]), .i_axis_6(ax[6]), .i_axis_7(ax[7]),
        .i_button_bits(button_bits),
        .o_valid(out_valid), .i_ready(out_ready),
        .o_kind(kind), .o_gesture_button(gesture_button),
        .o_value_a(va), .o_value_b(vb), .o_value_c(vc), .o_value_d(vd), .o_value_e(ve),
        .o_last(last),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic signed [63:0] sat_q15_8(input logic signed [63:0] v);
        if (v > 64'sd8388607) return 64'sd8388607;
        if (v < -64'sd8388608) return -64'sd8388608;
        return v;
    endfunction

    // deadzone, rescale and gain for one stick axis
    function automatic logic signed [63:0] scaled_axis(input t_frame f, input logic [2:0] idx,
                                                       input logic signed [15:0] gain);
        logic signed [63:0] a;
        logic [63:0] mag, r, g, q;
        logic neg;
        a = 64'(signed'(f.axis[idx]));
        mag = (a < 0) ? -a : a;
        if (mag < 64'(dz)) return 0;
        r = ((mag - dz) * 64'd32768) / (64'd32768 - dz);
        neg = (a < 0) != (gain < 0);
        g = (gain < 0) ? 64'(-64'(gain)) : 64'(gain);
        q = (r * g + 64'd16384) >> 15;
        return neg ? -$signed(q) : $signed(q);
    endfunction

    task automatic push_motion(input logic [1:0] k, input logic [3:0] b,
                               input logic signed [63:0] a0, a1, a2, a3, a4);
        t_motion m;
        m.kind = k;
        m.button = b;
        m.val[0] = 24'(sat_q15_8(a0));
        m.val[1] = 24'(sat_q15_8(a1));
        m.val[2] = 24'(sat_q15_8(a2));
        m.val[3] = 24'(sat_q15_8(a3));
        m.val[4] = 24'(sat_q15_8(a4));
        m.last = 1'b0;
        expected_motion.push_back(m);
    endtask

    task automatic predict_motion(input t_frame f);
        int n_queued;
        logic [2:0] a_fwd, a_side, a_turn, a_pitch;
        logic [3:0] deadman, posture;
        n_queued = expected_motion.size();
        a_fwd = cmap[2:0];
        a_side = cmap[5:3];
        a_turn = cmap[8:6];
        a_pitch = cmap[11:9];
        deadman = cmap[15:12];
        posture = cmap[19:16];
        if (f.req_type) begin
            if (seen_frame) begin
                if (quiet != 16'hFFFF) quiet = quiet + 16'd1;
                if (!stopped && quiet > timeout) begin
                    push_motion(jmcm_pkg::KIND_STOP, 0, 0, 0, 0, 0, 0);
                    stopped = 1'b1;
                end
            end
        end else begin
            seen_frame = 1'b1;
            quiet = 0;
            for (int i = 0; i < 16; i++)
                if (cmap[20 + i] && f.buttons[i] && !prev_buttons[i])
                    push_motion(jmcm_pkg::KIND_GESTURE, 4'(i), 0, 0, 0, 0, 0);
            if (f.buttons[posture]) begin
                push_motion(jmcm_pkg::KIND_POSE, 0,
                            64'(base_ht) + scaled_axis(f, a_fwd, jmcm_pkg::SCALE_HEIGHT),
                            scaled_axis(f, a_pitch, jmcm_pkg::SCALE_SHIFT),
                            scaled_axis(f, a_side, jmcm_pkg::SCALE_SHIFT),
                            scaled_axis(f, a_pitch, g_pitch),
                            scaled_axis(f, a_turn, jmcm_pkg::SCALE_YAW));
                if (!stopped) begin
                    push_motion(jmcm_pkg::KIND_STOP, 0, 0, 0, 0, 0, 0);
                    stopped = 1'b1;
                end
            end else if (f.buttons[deadman]) begin
                push_motion(jmcm_pkg::KIND_VEL, 0, scaled_axis(f, a_fwd, g_fwd),
                            scaled_axis(f, a_side, g_side), scaled_axis(f, a_turn, g_turn),
                            0, 0);
                stopped = 1'b0;
            end else if (!stopped) begin
                push_motion(jmcm_pkg::KIND_STOP, 0, 0, 0, 0, 0, 0);
                stopped = 1'b1;
            end
            prev_buttons = f.buttons;
        end
        if (expected_motion.size() > n_queued)
            expected_motion[expected_motion.size() - 1].last = 1'b1;
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got, want);
        fail_count++;
        $display("mismatch %s: got %0h want %0h", what, got, want);
    endtask

    // result side: random stall, field-by-field compare against the oldest expectation
    always @(posedge clk) begin
        t_motion m;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                result_count++;
                if (expected_motion.size() == 0) begin
                    report_mismatch("unexpected result kind", kind, 0);
                end else begin
                    m = expected_motion.pop_front();
                    if (kind !== m.kind) report_mismatch("kind", kind, m.kind);
                    if (gesture_button !== m.button)
                        report_mismatch("gesture_button", gesture_button, m.button);
                    if (va !== m.val[0]) report_mismatch("value_a", va, m.val[0]);
                    if (vb !== m.val[1]) report_mismatch("value_b", vb, m.val[1]);
                    if (vc !== m.val[2]) report_mismatch("value_c", vc, m.val[2]);
                    if (vd !== m.val[3]) report_mismatch("value_d", vd, m.val[3]);
                    if (ve !== m.val[4]) report_mismatch("value_e", ve, m.val[4]);
                    if (last !== m.last) report_mismatch("last", last, m.last);
                end
            end
        end
        out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog: cycles with no transaction on either channel
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", expected_motion.size());
            $display("status: fail");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= jmcm_pkg::APB_AW'({idx, 3'b000});
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            jmcm_pkg::REG_DEADZONE: dz = value[14:0];
            jmcm_pkg::REG_GAIN_FWD: g_fwd = value[15:0];
            jmcm_pkg::REG_GAIN_SID: g_side = value[15:0];
            jmcm_pkg::REG_GAIN_TRN: g_turn = value[15:0];
            jmcm_pkg::REG_GAIN_PIT: g_pitch = value[15:0];
            jmcm_pkg::REG_BASE_HT: base_ht = value[15:0];
            jmcm_pkg::REG_TIMEOUT: timeout = value[15:0];
            jmcm_pkg::REG_CTRL_MAP: cmap = value[35:0];
            default: ;
        endcase
    endtask

    // drop valid, wait for every expected result, then let a frame with no result drain
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_motion.size() != 0) @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic send_frame(input t_frame f);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= f.req_type;
        for (int i = 0; i < 8; i++) ax[i] <= f.axis[i];
        button_bits <= f.buttons;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_motion(f);
    endtask

    function automatic logic [15:0] rand_axis();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(200)) - 16'd100;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_frame rand_frame();
        t_frame f;
        f.req_type = ($urandom_range(3) == 0);
        for (int i = 0; i < 8; i++) f.axis[i] = rand_axis();
        f.buttons = 16'($urandom) & 16'($urandom);
        // keep the mapped deadman and posture buttons in play
        if ($urandom_range(1)) f.buttons[cmap[15:12]] = 1'b1;
        if ($urandom_range(3) == 0) f.buttons[cmap[19:16]] = 1'b1;
        return f;
    endfunction

    task automatic run_random(input int count, input int s_pct, input int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        repeat (count) send_frame(rand_frame());
    endtask

    initial begin
        t_row rows [$];
        t_frame f;
        t_motion m;
        fail_count = 0;
        result_count = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        req_type = 1'b0;
        for (int i = 0; i < 8; i++) ax[i] = '0;
        button_bits = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        dz = jmcm_pkg::RST_DEADZONE;
        g_fwd = jmcm_pkg::RST_GAIN;
        g_side = jmcm_pkg::RST_GAIN;
        g_turn = jmcm_pkg::RST_GAIN;
        g_pitch = jmcm_pkg::RST_GAIN;
        base_ht = jmcm_pkg::RST_BASE;
        timeout = jmcm_pkg::RST_TIMEOUT;
        cmap = jmcm_pkg::RST_MAP;
        prev_buttons = '0;
        stopped = 1'b0;
        seen_frame = 1'b0;
        quiet = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset map: fwd 1, side 0, turn 3, pitch 4, deadman 6, posture 4, gestures 0..3
        rows = '{
            '{1, 0, 0, 16'h0000, 1, jmcm_pkg::KIND_STOP, 0, 0},     // tick before any frame
            '{0, 0, 0, 16'h0000, 1, jmcm_pkg::KIND_STOP, 0, 24'h0}, // first frame: stop once
            '{0, 0, 0, 16'h0000, 0, 0, 0, 0},               // stop already sent: silent
            '{0, 16'h7FFF, 16'h7FFF, 16'h0040, 0, 0, 0, 0}, // deadman, full deflection
            '{0, 16'h8000, 16'h8000, 16'h0040, 0, 0, 0, 0}, // deadman, most negative
            '{0, 16'h0100, 16'h0100, 16'h0040, 0, 0, 0, 0}, // inside deadzone
            '{0, 0, 16'h7FFF, 16'h0050, 0, 0, 0, 0},        // posture over deadman, extra stop
            '{0, 0, 16'h8000, 16'h0050, 0, 0, 0, 0},        // posture again, no extra stop
            '{0, 0, 0, 16'h0CCF, 0, 0, 0, 0},               // gesture rising edges
            '{0, 0, 0, 16'hFFFF, 0, 0, 0, 0},               // every button
            '{1, 0, 0, 16'h0000, 0, 0, 0, 0},
            '{0, 0, 0, 16'h0040, 0, 0, 0, 0},               // velocity clears the stop
            '{1, 0, 0, 0, 0, 0, 0, 0}, '{1, 0, 0, 0, 0, 0, 0, 0},
            '{1, 0, 0, 0, 0, 0, 0, 0}, '{1, 0, 0, 0, 0, 0, 0, 0},
            '{1, 0, 0, 0, 0, 0, 0, 0},
            '{1, 0, 0, 0, 1, jmcm_pkg::KIND_STOP, 0, 0},    // sixth tick: watchdog stop
            '{1, 0, 0, 0, 0, 0, 0, 0}                       // stop already sent: silent
        };
        foreach (rows[r]) begin
            f.req_type = rows[r].req_type;
            for (int i = 0; i < 8; i++) f.axis[i] = 16'(16'h1234 * i);
            f.axis[0] = rows[r].ax0;
            f.axis[1] = rows[r].ax0;
            f.axis[3] = rows[r].ax1;
            f.axis[4] = rows[r].ax1;
            f.buttons = rows[r].buttons;
            send_frame(f);
            // spot-check predictor against the typed-in rows
            if (rows[r].typed && r != 0) begin
                m = expected_motion[expected_motion.size() - 1];
                if (m.kind !== rows[r].kind || m.val[0] !== rows[r].va)
                    report_mismatch("directed row", r, rows[r].kind);
            end
            if (r == 0 && expected_motion.size() != 0)
                report_mismatch("tick before frame", expected_motion.size(), 0);
        end
        drain();

        // extremes, every register written; remap so axes 6 and 7 get used
        write_reg(jmcm_pkg::REG_DEADZONE, 64'd0);
        write_reg(jmcm_pkg::REG_GAIN_FWD, 64'h7FFF);
        write_reg(jmcm_pkg::REG_GAIN_SID, 64'h8000);
        write_reg(jmcm_pkg::REG_GAIN_TRN, 64'hFFFF);
        write_reg(jmcm_pkg::REG_GAIN_PIT, 64'h8000);
        write_reg(jmcm_pkg::REG_BASE_HT, 64'h7FFF);
        write_reg(jmcm_pkg::REG_TIMEOUT, 64'd0);
        write_reg(jmcm_pkg::REG_CTRL_MAP, {28'hFFFF_FFF, 4'hF, 4'h0} | 36'h0_0000_0F7E);
        run_random(100, 19, 54);
        drain();

        write_reg(jmcm_pkg::REG_DEADZONE, 64'd32767);
        write_reg(jmcm_pkg::REG_BASE_HT, 64'h8000);
        write_reg(jmcm_pkg::REG_TIMEOUT, 64'd65535);
        write_reg(jmcm_pkg::REG_CTRL_MAP, {16'h5A5A, 4'h9, 4'h2, 3'd5, 3'd6, 3'd7, 3'd2});
        run_random(60, 54, 19);
        drain();

        write_reg(jmcm_pkg::REG_DEADZONE, 64'd1000);
        write_reg(jmcm_pkg::REG_GAIN_FWD, 64'h0100);
        write_reg(jmcm_pkg::REG_GAIN_SID, 64'h0200);
        write_reg(jmcm_pkg::REG_GAIN_TRN, 64'hFE00);
        write_reg(jmcm_pkg::REG_GAIN_PIT, 64'h0080);
        write_reg(jmcm_pkg::REG_BASE_HT, 64'h0100);
        write_reg(jmcm_pkg::REG_TIMEOUT, 64'd2);
        write_reg(jmcm_pkg::REG_CTRL_MAP, 36'($urandom) | (36'($urandom) << 32));
        run_random(70, 54, 19);
        drain();
        run_random(80, 0, 0);
        drain();

        repeat (200) @(posedge clk);
        $display("covered directed edge cases and %0d results across four register settings",
                 result_count);
        $display("with sender and receiver stalls in both proportions and a stall-free phase");
        if (fail_count == 0 && expected_motion.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/jmcm_pkg.sv
rtl/jmcm_ctrl.sv
rtl/jmcm_dp.sv
rtl/joystick_motion_command_mapper_top.sv
bench/tb_joystick_motion_command_mapper_top.sv
